@@ src/b2b_pkg.sv @@
// Shared types, constants and helper functions of the BLAKE2b hash engine.
`default_nettype none
package b2b_pkg;

   typedef logic [63:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_INIT,
      ST_ROUND,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   // Four steps of one mixing function, each with at most one wide add chain.
   typedef enum logic [1:0] {
      PH_ADD_X,
      PH_ROT32,
      PH_ROT24,
      PH_ROT16
   } phase_type;

   localparam logic [0:0] CSR_DIGEST_LENGTH = 1'b0;
   localparam logic [0:0] CSR_KEY_LENGTH    = 1'b1;

   localparam logic [6:0] DIGEST_LENGTH_RESET = 7'd64;
   localparam logic [6:0] KEY_LENGTH_RESET    = 7'd0;
   localparam logic [7:0] BLOCK_BYTES         = 8'd128;
   localparam logic [3:0] LAST_ROUND          = 4'd11;
   localparam logic [3:0] WORD_BYTES          = 4'd8;

   localparam word_type IV [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [3:0] SIGMA [12][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
   };

   function automatic word_type rotr(word_type x, int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

endpackage
`default_nettype wire

@@ src/b2b_channel_if.sv @@
// Valid/ready channel interfaces for message items and digest items.
`default_nettype none
interface b2b_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] message_word;
   logic [3:0]  valid_bytes;
   logic        end_of_message;

   modport source(output valid, message_word, valid_bytes, end_of_message, input ready);
   modport sink(input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface b2b_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source(output valid, digest_word, word_index, last_word, input ready);
   modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

@@ src/b2b_mix.sv @@
// Shared mixing unit: one quarter of the BLAKE2b G function per cycle.
`default_nettype none
module b2b_mix import b2b_pkg::*; (
   input  phase_type phase,
   input  word_type  a,
   input  word_type  b,
   input  word_type  c,
   input  word_type  d,
   input  word_type  m,
   output word_type  a_out,
   output word_type  b_out,
   output word_type  c_out,
   output word_type  d_out
);

   word_type t;
   word_type c_sum;

   always_comb begin
      a_out = a;
      b_out = b;
      c_out = c;
      d_out = d;
      t     = '0;
      c_sum = '0;
      unique case (phase)
         PH_ADD_X: begin
            a_out = a + b + m;
         end
         PH_ROT32: begin
            t     = rotr(d ^ a, 32);
            d_out = t;
            c_out = c + t;
         end
         PH_ROT24: begin
            t     = rotr(b ^ c, 24);
            b_out = t;
            a_out = a + t + m;
         end
         PH_ROT16: begin
            // The final rotate by 63 is wiring after the add, so it folds in here.
            t     = rotr(d ^ a, 16);
            c_sum = c + t;
            d_out = t;
            c_out = c_sum;
            b_out = rotr(b ^ c_sum, 63);
         end
         default: begin
            a_out = a;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ src/blake2b_hash.sv @@
// Top level of the sequential BLAKE2b-512 hash engine.
//
// Message items arrive on req: up to eight bytes, first byte in bits 7..0,
// with a count of valid bytes and an end-of-message flag. req.ready is high
// only while the engine is idle. Each accepted item occupies the engine from
// its accept in idle, through absorbing its valid bytes one at a time, to the
// step that closes the item. A full buffer is compressed only when a further
// byte arrives; after the absorb step that finds it full, one compression
// loads the working state, runs 12 rounds of 8 mixing functions through the
// single shared mixing unit, one phase at a time, and updates the chain.
// On end of message the last block is compressed with the final flag set and
// eight digest items leave on rsp, word 0 first, one per cycle while
// rsp.ready is high; the engine holds the current item when rsp stalls.
// After the eighth item the engine re-initialises for the next message.
// Writing either csr register re-initialises it as well. Reset restores
// digest length 64 and key length 0 and clears all message state.
`default_nettype none
module blake2b_hash import b2b_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   b2b_req_if.sink    req,
   b2b_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [6:0] csr_wdata
);

   state_type               state_ff, state_in;
   logic [6:0]              dlen_ff, dlen_in;
   logic [6:0]              klen_ff, klen_in;
   word_type [7:0]          h_ff, h_in;
   logic [127:0]            cnt_ff, cnt_in;
   word_type [15:0]         buf_ff, buf_in;
   logic [7:0]              fill_ff, fill_in;
   word_type                word_ff, word_in;
   logic [3:0]              nbytes_ff, nbytes_in;
   logic [3:0]              bidx_ff, bidx_in;
   logic                    eom_ff, eom_in;
   logic                    final_ff, final_in;
   word_type [3:0][3:0]     v_ff, v_in;
   logic [3:0]              round_ff, round_in;
   logic [2:0]              g_ff, g_in;
   phase_type               phase_ff, phase_in;
   logic [2:0]              oidx_ff, oidx_in;

   word_type                mix_m;
   word_type                mix_a, mix_b, mix_c, mix_d;
   word_type [3:0][3:0]     v_mixed;
   logic [7:0]              cur_byte;
   logic [1:0]              rot_amt [4];

   function automatic word_type [7:0] fresh_chain(logic [6:0] dl, logic [6:0] kl);
      word_type [7:0] hv;
      for (int i = 0; i < 8; i++) begin
         hv[i] = IV[i];
      end
      hv[0] = hv[0] ^ (64'(dl) | (64'(kl) << 8) | (64'd1 << 16) | (64'd1 << 24));
      return hv;
   endfunction

   function automatic word_type [3:0] rotl_row(word_type [3:0] row, logic [1:0] amt);
      word_type [3:0] res;
      for (int j = 0; j < 4; j++) begin
         res[j] = row[2'(j + int'(amt))];
      end
      return res;
   endfunction

   // Rows are rotated so the active column or diagonal always sits in slot 0.
   b2b_mix u_mix (
      .phase (phase_ff),
      .a     (v_ff[0][0]),
      .b     (v_ff[1][0]),
      .c     (v_ff[2][0]),
      .d     (v_ff[3][0]),
      .m     (mix_m),
      .a_out (mix_a),
      .b_out (mix_b),
      .c_out (mix_c),
      .d_out (mix_d)
   );

   assign mix_m    = buf_ff[SIGMA[round_ff][{g_ff, phase_ff[1]}]];
   assign cur_byte = word_ff[{bidx_ff[2:0], 3'b000} +: 8];

   always_comb begin
      v_mixed       = v_ff;
      v_mixed[0][0] = mix_a;
      v_mixed[1][0] = mix_b;
      v_mixed[2][0] = mix_c;
      v_mixed[3][0] = mix_d;
      for (int r = 0; r < 4; r++) begin
         if (g_ff == 3'd3) begin
            rot_amt[r] = 2'(1 + r);
         end else if (g_ff == 3'd7) begin
            rot_amt[r] = 2'(1 - r);
         end else begin
            rot_amt[r] = 2'd1;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            if (bidx_ff < nbytes_ff) begin
               if (fill_ff == BLOCK_BYTES) begin
                  state_in = ST_INIT;
               end
            end else if (eom_ff) begin
               state_in = ST_INIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND && g_ff == 3'd7 && phase_ff == PH_ROT16) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = final_ff ? ST_OUTPUT : ST_ABSORB;
         end
         ST_OUTPUT: begin
            if (rsp.ready && oidx_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      dlen_in   = dlen_ff;
      klen_in   = klen_ff;
      h_in      = h_ff;
      cnt_in    = cnt_ff;
      buf_in    = buf_ff;
      fill_in   = fill_ff;
      word_in   = word_ff;
      nbytes_in = nbytes_ff;
      bidx_in   = bidx_ff;
      eom_in    = eom_ff;
      final_in  = final_ff;
      v_in      = v_ff;
      round_in  = round_ff;
      g_in      = g_ff;
      phase_in  = phase_ff;
      oidx_in   = oidx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               word_in   = req.message_word;
               nbytes_in = (req.valid_bytes > WORD_BYTES) ? WORD_BYTES : req.valid_bytes;
               eom_in    = req.end_of_message;
               bidx_in   = '0;
            end
         end
         ST_ABSORB: begin
            if (bidx_ff < nbytes_ff) begin
               if (fill_ff == BLOCK_BYTES) begin
                  cnt_in   = cnt_ff + 128'(fill_ff);
                  final_in = 1'b0;
               end else begin
                  buf_in[fill_ff[6:3]][{fill_ff[2:0], 3'b000} +: 8] = cur_byte;
                  fill_in = fill_ff + 8'd1;
                  bidx_in = bidx_ff + 4'd1;
               end
            end else if (eom_ff) begin
               cnt_in   = cnt_ff + 128'(fill_ff);
               final_in = 1'b1;
            end
         end
         ST_INIT: begin
            for (int i = 0; i < 4; i++) begin
               v_in[0][i] = h_ff[i];
               v_in[1][i] = h_ff[i + 4];
               v_in[2][i] = IV[i];
               v_in[3][i] = IV[i + 4];
            end
            v_in[3][0] = IV[4] ^ cnt_ff[63:0];
            v_in[3][1] = IV[5] ^ cnt_ff[127:64];
            v_in[3][2] = final_ff ? ~IV[6] : IV[6];
            round_in   = '0;
            g_in       = '0;
            phase_in   = PH_ADD_X;
         end
         ST_ROUND: begin
            unique case (phase_ff)
               PH_ADD_X: phase_in = PH_ROT32;
               PH_ROT32: phase_in = PH_ROT24;
               PH_ROT24: phase_in = PH_ROT16;
               PH_ROT16: phase_in = PH_ADD_X;
               default:  phase_in = PH_ADD_X;
            endcase
            if (phase_ff == PH_ROT16) begin
               for (int r = 0; r < 4; r++) begin
                  v_in[r] = rotl_row(v_mixed[r], rot_amt[r]);
               end
               g_in = g_ff + 3'd1;
               if (g_ff == 3'd7) begin
                  round_in = round_ff + 4'd1;
               end
            end else begin
               v_in = v_mixed;
            end
         end
         ST_FINISH: begin
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] ^ v_ff[i / 4][i % 4] ^ v_ff[2 + i / 4][i % 4];
            end
            if (!final_ff) begin
               buf_in  = '0;
               fill_in = '0;
            end
            oidx_in = '0;
         end
         ST_OUTPUT: begin
            if (rsp.ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  h_in    = fresh_chain(dlen_ff, klen_ff);
                  cnt_in  = '0;
                  buf_in  = '0;
                  fill_in = '0;
               end
            end
         end
         default: begin
            oidx_in = oidx_ff;
         end
      endcase

      // Register writes must arrive only while idle; the block does not enforce it. They restart the message.
      if (csr_we) begin
         if (csr_index == CSR_DIGEST_LENGTH) begin
            dlen_in = csr_wdata;
         end
         if (csr_index == CSR_KEY_LENGTH) begin
            klen_in = csr_wdata;
         end
         h_in    = fresh_chain(dlen_in, klen_in);
         cnt_in  = '0;
         buf_in  = '0;
         fill_in = '0;
      end
   end

   // Outputs
   always_comb begin
      req.ready       = (state_ff == ST_IDLE);
      rsp.valid       = (state_ff == ST_OUTPUT);
      rsp.digest_word = h_ff[oidx_ff];
      rsp.word_index  = oidx_ff;
      rsp.last_word   = (oidx_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dlen_ff  <= DIGEST_LENGTH_RESET;
         klen_ff  <= KEY_LENGTH_RESET;
         h_ff     <= fresh_chain(DIGEST_LENGTH_RESET, KEY_LENGTH_RESET);
         cnt_ff   <= '0;
         buf_ff   <= '0;
         fill_ff  <= '0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dlen_ff  <= dlen_in;
         klen_ff  <= klen_in;
         h_ff     <= h_in;
         cnt_ff   <= cnt_in;
         buf_ff   <= buf_in;
         fill_ff  <= fill_in;
         oidx_ff  <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      nbytes_ff <= nbytes_in;
      bidx_ff   <= bidx_in;
      eom_ff    <= eom_in;
      final_ff  <= final_in;
      v_ff      <= v_in;
      round_ff  <= round_in;
      g_ff      <= g_in;
      phase_ff  <= phase_in;
   end

endmodule
`default_nettype wire

@@ tb/tb_blake2b_hash.sv @@
// Self-checking testbench of the BLAKE2b hash engine: random messages against a built-in model.
`default_nettype none
module tb_blake2b_hash;
   import b2b_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_type;

   // Holds the engine state as predicted and the digest items still owed.
   class scoreboard_type;
      logic [6:0]   dig_len;
      logic [6:0]   key_len;
      word_type     chain [8];
      logic [127:0] byte_count;
      word_type     block [16];
      int unsigned  fill;
      digest_item_type pending [$];
      int           errors;

      function new();
         dig_len = DIGEST_LENGTH_RESET;
         key_len = KEY_LENGTH_RESET;
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = IV[i];
         chain[0] ^= {32'd0, 8'd1, 8'd1, 1'b0, key_len, 1'b0, dig_len};
         byte_count = '0;
         for (int i = 0; i < 16; i++) block[i] = '0;
         fill = 0;
      endfunction

      function void write_reg(logic [0:0] idx, logic [6:0] val);
         if (idx == CSR_DIGEST_LENGTH) dig_len = val;
         else key_len = val;
         restart();
      endfunction

      function word_type ror(word_type x, int n);
         return (x >> n) | (x << (64 - n));
      endfunction

      function void compress(bit final_block);
         word_type v [16];
         int a [8], b [8], c [8], d [8];
         a = '{0, 1, 2, 3, 0, 1, 2, 3};
         b = '{4, 5, 6, 7, 5, 6, 7, 4};
         c = '{8, 9, 10, 11, 10, 11, 8, 9};
         d = '{12, 13, 14, 15, 15, 12, 13, 14};
         for (int i = 0; i < 8; i++) begin
            v[i] = chain[i];
            v[i+8] = IV[i];
         end
         v[12] ^= byte_count[63:0];
         v[13] ^= byte_count[127:64];
         if (final_block) v[14] = ~v[14];
         for (int r = 0; r < 12; r++) begin
            for (int g = 0; g < 8; g++) begin
               v[a[g]] = v[a[g]] + v[b[g]] + block[SIGMA[r][2*g]];
               v[d[g]] = ror(v[d[g]] ^ v[a[g]], 32);
               v[c[g]] = v[c[g]] + v[d[g]];
               v[b[g]] = ror(v[b[g]] ^ v[c[g]], 24);
               v[a[g]] = v[a[g]] + v[b[g]] + block[SIGMA[r][2*g+1]];
               v[d[g]] = ror(v[d[g]] ^ v[a[g]], 16);
               v[c[g]] = v[c[g]] + v[d[g]];
               v[b[g]] = ror(v[b[g]] ^ v[c[g]], 63);
            end
         end
         for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
      endfunction

      function void note_message(logic [63:0] w, logic [3:0] nb, logic eom);
         int n;
         digest_item_type it;
         n = (nb > 8) ? 8 : nb;
         for (int i = 0; i < n; i++) begin
            if (fill >= 128) begin
               byte_count += 128;
               compress(0);
               for (int k = 0; k < 16; k++) block[k] = '0;
               fill = 0;
            end
            block[fill / 8] |= word_type'(w[8*i +: 8]) << (8 * (fill % 8));
            fill++;
         end
         if (eom) begin
            byte_count += fill;
            compress(1);
            for (int i = 0; i < 8; i++) begin
               it.digest_word = chain[i];
               it.word_index = 3'(i);
               it.last_word = (i == 7);
               pending.push_back(it);
            end
            restart();
         end
      endfunction

      function void check_digest(digest_item_type got);
         digest_item_type exp_item;
         if (pending.size() == 0) begin
            $error("digest item with none expected: %h", got.digest_word);
            errors++;
            return;
         end
         exp_item = pending.pop_front();
         if (got.digest_word !== exp_item.digest_word) begin
            $error("digest_word: expected %h, got %h", exp_item.digest_word, got.digest_word);
            errors++;
         end
         if (got.word_index !== exp_item.word_index) begin
            $error("word_index: expected %0d, got %0d", exp_item.word_index, got.word_index);
            errors++;
         end
         if (got.last_word !== exp_item.last_word) begin
            $error("last_word: expected %0d, got %0d", exp_item.last_word, got.last_word);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [0:0] csr_index = '0;
   logic [6:0] csr_wdata = '0;
   b2b_req_if req ();
   b2b_rsp_if rsp ();
   scoreboard_type sb;
   int idle_cycles = 0;
   int sent_items = 0;
   bit rsp_stall_on = 1;
   localparam int WATCHDOG = 20000;

   blake2b_hash u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Sink side: random ready, checking each accepted digest item.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_digest({rsp.digest_word, rsp.word_index, rsp.last_word});
   end
   initial begin
      int g;
      rsp.ready = 0;
      @(negedge clock);
      forever begin
         g = rsp_stall_on ? gap_len() : 0;
         rsp.ready = (g == 0);
         repeat (g == 0 ? 1 : g) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_word(logic [63:0] w, logic [3:0] nb, logic eom, bit pause);
      int g;
      g = pause ? gap_len() : 0;
      if (g > 0) begin
         req.valid = 0;
         repeat (g) @(negedge clock);
      end
      req.valid = 1;
      req.message_word = w;
      req.valid_bytes = nb;
      req.end_of_message = eom;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_message(w, nb, eom);
      sent_items++;
      @(negedge clock);
      req.valid = 0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      // The engine may still be absorbing after its last digest item.
      repeat (600) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [6:0] val);
      drain();
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   function logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_message(int max_words);
      int n;
      n = $urandom_range(max_words, 0);
      for (int i = 0; i < n; i++) begin
         // Occasional partial or empty words mid-message.
         if ($urandom_range(9) == 0) send_word(rand64(), 4'($urandom_range(15)), 0, 1);
         else send_word(rand64(), 4'd8, 0, 1);
      end
      send_word(rand64(), 4'($urandom_range(15)), 1, 1);
   endtask

   initial begin
      req.valid = 0;
      req.message_word = '0;
      req.valid_bytes = '0;
      req.end_of_message = 0;
      sb = new();
      repeat (7) @(negedge clock);
      reset = 0;
      @(negedge clock);
      // Directed items: empty message, field extremes, partial words, full blocks.
      send_word('0, 4'd0, 1, 0);
      send_word('1, 4'd8, 1, 0);
      send_word('0, 4'd8, 1, 0);
      send_word(64'h0000000000636261, 4'd3, 1, 0);
      send_word(rand64(), 4'd15, 1, 0);
      send_word(rand64(), 4'd0, 0, 0);
      send_word(rand64(), 4'd3, 0, 0);
      send_word(rand64(), 4'd5, 1, 0);
      for (int i = 0; i < 16; i++) send_word(rand64(), 4'd8, i == 15, 0);
      send_word(rand64(), 4'd9, 1, 1);
      write_csr(CSR_DIGEST_LENGTH, 7'd1);
      write_csr(CSR_KEY_LENGTH, 7'd64);
      random_message(20);
      write_csr(CSR_DIGEST_LENGTH, 7'd127);
      write_csr(CSR_KEY_LENGTH, 7'd0);
      // A register write part-way through a message discards it.
      send_word(rand64(), 4'd8, 0, 0);
      write_csr(CSR_DIGEST_LENGTH, 7'd64);
      while (sent_items < 400) begin
         rsp_stall_on = ($urandom_range(4) != 0);
         random_message($urandom_range(5) == 0 ? 40 : 6);
         if ($urandom_range(7) == 0) begin
            write_csr(1'($urandom_range(1)), 7'($urandom_range(127)));
         end
         if ($urandom_range(9) == 0) drain();
      end
      rsp_stall_on = 1;
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
